@@ sv/temperature_average_reporter_assert.svh @@
// Assertion macros shared by the temperature average reporter modules.
`ifndef TEMPERATURE_AVERAGE_REPORTER_ASSERT_SVH
`define TEMPERATURE_AVERAGE_REPORTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tar assertion failed");

// Next-cycle implication, checked outside reset.
`define TAR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tar assertion failed");

`endif

@@ sv/tar_pkg.sv @@
// Package with types, constants and arithmetic helpers for the temperature average reporter.
package tar_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TIME_W          = 32;
  localparam int TEMP_W          = 26;
  localparam int DEG_W           = 16;
  localparam int INTERVAL_W      = 13;

  localparam int RAW_OFFSET    = 1150;
  localparam int MDEG_STEP_INT = 500;
  localparam int MDEG_BASE     = 30000;

  localparam logic signed [TEMP_W-1:0] MDEG_PER_STEP = TEMP_W'(MDEG_STEP_INT);
  localparam logic signed [TEMP_W-1:0] TEMP_ZERO =
    TEMP_W'(MDEG_BASE - RAW_OFFSET * MDEG_STEP_INT);

  localparam logic signed [TEMP_W:0] DEADBAND   = 27'sd1000;
  localparam logic signed [TEMP_W:0] ROUND_HALF = 27'sd500;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 13'd10;
  localparam logic [TIME_W-1:0]     US_PER_S       = 32'd1000000;
  localparam logic [TIME_W-1:0]     LIMIT_RESET    = 32'(10 * 1000000);

  // Reciprocals for exact truncating division of bounded magnitudes.
  localparam logic [31:0] DIV50_MUL     = 32'd2748779070;
  localparam int          DIV50_SHIFT   = 37;
  localparam logic [25:0] DIV1000_MUL   = 26'd34359739;
  localparam int          DIV1000_SHIFT = 35;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] avg;
    logic [TIME_W-1:0]        now;
    logic                     busy;
    logic                     first;
  } avg_item_t;

  function automatic logic signed [TEMP_W-1:0] avg_update(
    input logic signed [TEMP_W-1:0] avg,
    input logic signed [TEMP_W-1:0] t
  );
    logic signed [31:0] x;
    logic [30:0]        mag;
    logic [62:0]        p;
    logic [TEMP_W-1:0]  q;
    x   = 32'(avg) * 32'sd49 + 32'(t);
    mag = x[31] ? 31'(-x) : 31'(x);
    p   = 63'(mag) * 63'(DIV50_MUL);
    q   = TEMP_W'(p >> DIV50_SHIFT);
    return x[31] ? TEMP_W'(-$signed(q)) : $signed(q);
  endfunction

  function automatic logic signed [DEG_W-1:0] round_degrees(
    input logic signed [TEMP_W-1:0] avg
  );
    logic signed [TEMP_W:0] x;
    logic [TEMP_W-1:0]      mag;
    logic [51:0]            p;
    logic [DEG_W-1:0]       q;
    x   = 27'(avg) + ROUND_HALF;
    mag = x[TEMP_W] ? TEMP_W'(-x) : x[TEMP_W-1:0];
    p   = 52'(mag) * 52'(DIV1000_MUL);
    q   = DEG_W'(p >> DIV1000_SHIFT);
    return x[TEMP_W] ? DEG_W'(-$signed(q)) : $signed(q);
  endfunction

endpackage

@@ sv/tar_avg.sv @@
// Input register and running-average stage of the temperature average reporter.
module tar_avg #(
  parameter int SAMPLE_BITS = tar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tar_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [tar_pkg::TIME_W-1:0]    in_time,
  input  logic                          in_busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tar_pkg::avg_item_t            out_item
);

  logic                             v1;
  logic [SAMPLE_BITS-1:0]           sample1;
  logic [tar_pkg::TIME_W-1:0]       time1;
  logic                             busy1;
  logic                             v2;
  logic                             seeded;
  logic signed [tar_pkg::TEMP_W-1:0] average;
  logic signed [tar_pkg::TEMP_W-1:0] temp2;
  logic [tar_pkg::TIME_W-1:0]       time2;
  logic                             busy2;
  logic                             first2;
  logic                             en1;
  logic                             en2;
  logic signed [tar_pkg::TEMP_W-1:0] temp_c;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign temp_c = $signed({{(tar_pkg::TEMP_W - SAMPLE_BITS){1'b0}}, sample1})
                  * tar_pkg::MDEG_PER_STEP + tar_pkg::TEMP_ZERO;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1 && in_valid) begin
      sample1 <= in_sample[SAMPLE_BITS-1:0];
      time1   <= in_time;
      busy1   <= in_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2      <= 1'b0;
      seeded  <= 1'b0;
      average <= '0;
    end else if (en2) begin
      v2 <= v1;
      if (v1) begin
        seeded  <= 1'b1;
        average <= seeded ? tar_pkg::avg_update(average, temp_c) : temp_c;
      end
    end
    if (en2 && v1) begin
      temp2  <= temp_c;
      time2  <= time1;
      busy2  <= busy1;
      first2 <= !seeded;
    end
  end

  assign out_valid      = v2;
  assign out_item.temp  = temp2;
  assign out_item.avg   = average;
  assign out_item.now   = time2;
  assign out_item.busy  = busy2;
  assign out_item.first = first2;

`include "temperature_average_reporter_assert.svh"

  `TAR_ASSERT_NXT(a_seeded_after_item, en2 && v1, seeded)
  `TAR_ASSERT_NXT(a_first_only_once, en2 && v1 && seeded, !first2)
  `TAR_ASSERT_IMP(a_ready_when_empty, !v1, in_ready)

endmodule

@@ sv/tar_report.sv @@
// Report decision, rounding and output register of the temperature average reporter.
module tar_report (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [tar_pkg::INTERVAL_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tar_pkg::avg_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [tar_pkg::TEMP_W-1:0] out_temp,
  output logic signed [tar_pkg::TEMP_W-1:0] out_avg,
  output logic                             out_report,
  output logic signed [tar_pkg::DEG_W-1:0] out_degrees
);

  logic [tar_pkg::TIME_W-1:0]        limit;
  logic                              rep_en;
  logic                              v3;
  logic signed [tar_pkg::TEMP_W-1:0] temp3;
  logic signed [tar_pkg::TEMP_W-1:0] avg3;
  logic                              rep3;
  logic signed [tar_pkg::TEMP_W-1:0] last_rep;
  logic [tar_pkg::TIME_W-1:0]        last_time;
  logic                              v4;
  logic signed [tar_pkg::TEMP_W-1:0] temp4;
  logic signed [tar_pkg::TEMP_W-1:0] avg4;
  logic                              rep4;
  logic signed [tar_pkg::DEG_W-1:0]  deg4;
  logic                              en3;
  logic                              en4;
  logic [tar_pkg::TIME_W-1:0]        elapsed;
  logic signed [tar_pkg::TEMP_W:0]   diff;
  logic                              report_c;
  logic                              fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit  <= tar_pkg::LIMIT_RESET;
      rep_en <= 1'b1;
    end else if (cfg_wen) begin
      limit  <= 32'(cfg_wdata) * tar_pkg::US_PER_S;
      rep_en <= cfg_wdata != '0;
    end
  end

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  assign elapsed  = in_item.now - last_time;
  assign diff     = 27'(in_item.avg) - 27'(last_rep);
  assign report_c = !in_item.first && rep_en && !in_item.busy && (elapsed > limit) &&
                    (diff > tar_pkg::DEADBAND || diff < -tar_pkg::DEADBAND);
  assign fire     = in_valid && en3 && report_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      last_rep  <= '0;
      last_time <= '0;
    end else if (en3) begin
      v3 <= in_valid;
      if (in_valid && (in_item.first || report_c)) begin
        last_time <= in_item.now;
      end
      if (fire) begin
        last_rep <= in_item.avg;
      end
    end
    if (en3 && in_valid) begin
      temp3 <= in_item.temp;
      avg3  <= in_item.avg;
      rep3  <= report_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4 && v3) begin
      temp4 <= temp3;
      avg4  <= avg3;
      rep4  <= rep3;
      deg4  <= rep3 ? tar_pkg::round_degrees(avg3) : '0;
    end
  end

  assign out_valid   = v4;
  assign out_temp    = temp4;
  assign out_avg     = avg4;
  assign out_report  = rep4;
  assign out_degrees = deg4;

`include "temperature_average_reporter_assert.svh"

  `TAR_ASSERT_NXT(a_last_rep_follows, fire, last_rep == $past(in_item.avg))
  `TAR_ASSERT_IMP(a_held_report_is_last, v3 && rep3, avg3 == last_rep)
  `TAR_ASSERT_IMP(a_no_report_zero_deg, v4 && !rep4, deg4 == '0)

endmodule

@@ sv/temperature_average_reporter.sv @@
// Top level of the temperature average reporter: stream ports and configuration.
//
//   Channel  | Direction | Contents
//   s_axis   | in        | raw sample, microsecond time, console busy flag
//   m_axis   | out       | temperature, average, report flag, rounded degrees
//   cfg      | in        | report interval in seconds, written when cfg_wen is high
//
// One item is taken per cycle unless the output stalls; outputs are registered.
// The running-average register is updated once per item.
// Reset clears the average, the report history and all valid flags at once.
// Each stage moves on when the next one is empty or moving, so bubbles close
// up and an item is taken while a result still waits on a stalled output.
module temperature_average_reporter #(
  parameter int SAMPLE_BITS = tar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sample_raw[15:0], time_now[47:16], console_busy[48], zero fill
  input  logic [55:0]                    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // temp_now[25:0], temp_average[51:26], report_valid[52], report_degrees[68:53], zero fill
  output logic [71:0]                    m_axis_tdata,
  input  logic                           cfg_wen,
  input  logic [tar_pkg::INTERVAL_W-1:0] cfg_wdata
);

  logic                              mid_valid;
  logic                              mid_ready;
  tar_pkg::avg_item_t                mid_item;
  logic signed [tar_pkg::TEMP_W-1:0] temp_now;
  logic signed [tar_pkg::TEMP_W-1:0] temp_average;
  logic                              report_valid;
  logic signed [tar_pkg::DEG_W-1:0]  report_degrees;

  tar_avg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_avg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata[15:0]),
    .in_time   (s_axis_tdata[47:16]),
    .in_busy   (s_axis_tdata[48]),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_item  (mid_item)
  );

  tar_report u_report (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (mid_valid),
    .in_ready    (mid_ready),
    .in_item     (mid_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_temp    (temp_now),
    .out_avg     (temp_average),
    .out_report  (report_valid),
    .out_degrees (report_degrees)
  );

  assign m_axis_tdata = {3'b000, report_degrees, report_valid, temp_average, temp_now};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the temperature average reporter stream block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = tar_pkg::SAMPLE_W;
  localparam int TIME_W      = tar_pkg::TIME_W;
  localparam int TEMP_W      = tar_pkg::TEMP_W;
  localparam int DEG_W       = tar_pkg::DEG_W;
  localparam int INTERVAL_W  = tar_pkg::INTERVAL_W;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PIPE_DRAIN  = 12;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 100;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((1 << tar_pkg::SAMPLE_BITS_DEF) - 1);

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_now;
    logic signed [TEMP_W-1:0] temp_avg;
    logic                     report;
    logic signed [DEG_W-1:0]  degrees;
  } reading_t;

  typedef struct {
    logic [SAMPLE_W-1:0] raw;
    logic [TIME_W-1:0]   stamp;
    logic                busy;
    bit                  typed;
    reading_t            want;
  } table_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [55:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [71:0]           m_axis_tdata;
  logic                  cfg_wen;
  logic [INTERVAL_W-1:0] cfg_wdata;

  // Predictor state and configuration.
  bit                    have_seed;
  longint                avg_mdeg;
  longint                reported_mdeg;
  logic [TIME_W-1:0]     reported_at;
  logic [INTERVAL_W-1:0] interval_s;

  reading_t   pending_readings[$];
  table_row_t dir_rows[$];
  reading_t   seen_reading;
  reading_t   oldest_reading;

  int                items_sent;
  int                results_seen;
  int                reports_seen;
  int                mismatches;
  int                idle_cycles;
  int                rx_gap;
  int                walk_raw;
  logic [TIME_W-1:0] clock_us;
  bit                hold_request;
  bit                rx_steady;
  bit                tx_steady;

  temperature_average_reporter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] raw,
                                               input logic [TIME_W-1:0] stamp,
                                               input logic busy);
    reading_t          r;
    longint            temp;
    longint            diff;
    longint            degrees;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] limit;
    logic              fire;
    temp    = (longint'(raw & SAMPLE_MASK) - tar_pkg::RAW_OFFSET) * tar_pkg::MDEG_STEP_INT
              + tar_pkg::MDEG_BASE;
    fire    = 1'b0;
    degrees = 0;
    if (!have_seed) begin
      have_seed   = 1'b1;
      avg_mdeg    = temp;
      reported_at = stamp;
    end else begin
      avg_mdeg = (avg_mdeg * 49 + temp) / 50;
      elapsed  = stamp - reported_at;
      limit    = TIME_W'(longint'(interval_s) * 1000000);
      diff     = avg_mdeg - reported_mdeg;
      if (interval_s != 0 && !busy && elapsed > limit && (diff > 1000 || diff < -1000)) begin
        fire          = 1'b1;
        degrees       = (avg_mdeg + 500) / 1000;
        reported_mdeg = avg_mdeg;
        reported_at   = stamp;
      end
    end
    r.temp_now = TEMP_W'(temp);
    r.temp_avg = TEMP_W'(avg_mdeg);
    r.report   = fire;
    r.degrees  = DEG_W'(degrees);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  task automatic rest_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic offer_reading(input logic [SAMPLE_W-1:0] raw, input logic [TIME_W-1:0] stamp,
                               input logic busy, input bit typed, input reading_t want);
    reading_t predicted;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, busy, stamp, raw};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    predicted = predict_reading(raw, stamp, busy);
    pending_readings.push_back(typed ? want : predicted);
    if (!tx_steady) rest_sender(pick_gap());
  endtask

  task automatic drain_results();
    rest_sender(1);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen    <= 1'b0;
    interval_s = value;
  endtask

  task automatic add_row(input logic [SAMPLE_W-1:0] raw, input logic [TIME_W-1:0] stamp,
                         input logic busy, input bit typed, input longint tn, input longint ta,
                         input logic rv, input longint deg);
    table_row_t row;
    row.raw            = raw;
    row.stamp          = stamp;
    row.busy           = busy;
    row.typed          = typed;
    row.want.temp_now  = TEMP_W'(tn);
    row.want.temp_avg  = TEMP_W'(ta);
    row.want.report    = rv;
    row.want.degrees   = DEG_W'(deg);
    dir_rows.push_back(row);
  endtask

  task automatic send_random_reading();
    int unsigned       r;
    logic [TIME_W-1:0] limit;
    logic [SAMPLE_W-1:0] raw;
    logic [TIME_W-1:0] stamp;
    logic              busy;
    limit = TIME_W'(longint'(interval_s) * 1000000);
    r     = $urandom_range(0, 99);
    if (r < 15) begin
      raw   = SAMPLE_W'($urandom);
      stamp = $urandom;
      busy  = 1'($urandom);
    end else begin
      walk_raw = walk_raw + int'($urandom_range(0, 40)) - 20;
      if ($urandom_range(0, 19) == 0) walk_raw = walk_raw + int'($urandom_range(0, 800)) - 400;
      if (walk_raw < 0) walk_raw = 0;
      if (walk_raw > 65535) walk_raw = 65535;
      raw  = SAMPLE_W'(walk_raw);
      busy = ($urandom_range(0, 9) == 0);
      if (r < 30) stamp = reported_at + limit;
      else if (r < 45) stamp = reported_at + limit + 1;
      else stamp = clock_us + (limit >> 1) +
                   $urandom_range(0, (limit == 0) ? 32'd5000000 : limit);
      clock_us = stamp;
    end
    offer_reading(raw, stamp, busy, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_reading.temp_now = m_axis_tdata[25:0];
      seen_reading.temp_avg = m_axis_tdata[51:26];
      seen_reading.report   = m_axis_tdata[52];
      seen_reading.degrees  = m_axis_tdata[68:53];
      results_seen++;
      if (seen_reading.report) reports_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result", longint'(seen_reading.temp_now), 0);
      end else begin
        oldest_reading = pending_readings.pop_front();
        if (seen_reading.temp_now !== oldest_reading.temp_now)
          report_mismatch("temp_now", seen_reading.temp_now, oldest_reading.temp_now);
        if (seen_reading.temp_avg !== oldest_reading.temp_avg)
          report_mismatch("temp_average", seen_reading.temp_avg, oldest_reading.temp_avg);
        if (seen_reading.report !== oldest_reading.report)
          report_mismatch("report_valid", seen_reading.report, oldest_reading.report);
        if (seen_reading.degrees !== oldest_reading.degrees)
          report_mismatch("report_degrees", seen_reading.degrees, oldest_reading.degrees);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady) rx_gap = pick_gap();
      end
    end
  end

  initial begin
    int phase_iv[7];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_wen       = 1'b0;
    cfg_wdata     = '0;
    hold_request  = 1'b0;
    rx_steady     = 1'b0;
    tx_steady     = 1'b0;
    rx_gap        = 0;
    idle_cycles   = 0;
    items_sent    = 0;
    results_seen  = 0;
    reports_seen  = 0;
    mismatches    = 0;
    walk_raw      = 1150;
    clock_us      = '0;
    have_seed     = 1'b0;
    avg_mdeg      = 0;
    reported_mdeg = 0;
    reported_at   = '0;
    interval_s    = tar_pkg::INTERVAL_RESET;

    // The seeding item and the one after it are worked out by hand.
    add_row(16'd1150,  32'd0,           1'b0, 1'b1, 30000, 30000, 1'b0, 0);
    add_row(16'd0,     32'd5,           1'b0, 1'b1, -545000, 18500, 1'b0, 0);
    add_row(16'd65535, 32'd10000000,    1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd65535, 32'd10000001,    1'b1, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd65535, 32'd10000001,    1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd65535, 32'd20000001,    1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd65535, 32'd20000002,    1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd0,     32'hFFFF_FF00,   1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd0,     32'h0000_0100,   1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd1150,  32'd9999745,     1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd1150,  32'd29999746,    1'b1, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd1150,  32'd49999747,    1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd1151,  32'd49999748,    1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'd1151,  32'd99999748,    1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'hAAAA,  32'hAAAA_AAAA,   1'b1, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'h5555,  32'h5555_5555,   1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'hFFFF,  32'hFFFF_FFFF,   1'b0, 1'b0, 0, 0, 1'b0, 0);
    add_row(16'h0000,  32'h0000_0000,   1'b0, 1'b0, 0, 0, 1'b0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      offer_reading(dir_rows[i].raw, dir_rows[i].stamp, dir_rows[i].busy,
                    dir_rows[i].typed, dir_rows[i].want);

    phase_iv = '{1, 0, 4294, 8191, 0, 2, 10};
    phase_iv[4] = int'($urandom_range(1, 8190));
    for (int p = 0; p < 7; p++) begin
      write_interval(INTERVAL_W'(phase_iv[p]));
      clock_us  = reported_at;
      tx_steady = (p == 1 || p == 5);
      rx_steady = (p == 5);
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) drain_results();
        send_random_reading();
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_results();

    $display("summary: %0d items sent, %0d results checked, %0d of them reports",
             items_sent, results_seen, reports_seen);
    $display("summary: intervals 10, 1, 0, 4294, 8191, %0d, 2 and 10 s; %0d mismatches",
             phase_iv[4], mismatches);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/tar_pkg.sv
sv/tar_avg.sv
sv/tar_report.sv
sv/temperature_average_reporter.sv
tb/tb.sv
